// ===== rtl/cache_hit_miss_model_assert.svh =====
// assertion macros for the cache model
`ifndef CACHE_HIT_MISS_MODEL_ASSERT_SVH
`define CACHE_HIT_MISS_MODEL_ASSERT_SVH
`ifndef SYNTHESIS
`define CHM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHM_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHM_ASSERT(label, clk, rst_n, prop, msg)
`define CHM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/chm_pkg.sv =====
package chm_pkg;
  localparam int LINES = 64;
  localparam int LW = 6;
  localparam int SW = 5;
  localparam logic [1:0] MODE_DM = 2'd0;
  localparam logic [1:0] MODE_2W = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_SET = 2'd2;
  localparam logic [LW-1:0] AGE_MAX = '1;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] offset_bits;
    logic [2:0] set_bits;
  } cfg_t;
endpackage

// ===== rtl/chm_cfg.sv =====
module chm_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output chm_pkg::cfg_t cfg
);
  chm_pkg::cfg_t cfg_r;
  logic [1:0] idx;
  assign idx = paddr[3:2];
  assign pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= chm_pkg::MODE_DM;
      cfg_r.offset_bits <= 5'd2;
      cfg_r.set_bits <= 3'd6;
    end else if (psel && penable && pwrite) begin
      case (idx)
        chm_pkg::REG_MODE:   cfg_r.mode <= pwdata[1:0];
        chm_pkg::REG_OFFSET: cfg_r.offset_bits <= pwdata[4:0];
        chm_pkg::REG_SET:    cfg_r.set_bits <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      chm_pkg::REG_MODE:   prdata = {30'd0, cfg_r.mode};
      chm_pkg::REG_OFFSET: prdata = {27'd0, cfg_r.offset_bits};
      chm_pkg::REG_SET:    prdata = {29'd0, cfg_r.set_bits};
      default:             prdata = 32'd0;
    endcase
  end
endmodule

// ===== rtl/chm_store.sv =====
// line memory: tag and age per line, one read and one write port
module chm_store (
  input  logic                    clk,
  input  logic [chm_pkg::LW-1:0]  raddr,
  output logic [31:0]             rtag,
  output logic [chm_pkg::LW-1:0]  rage,
  input  logic                    we,
  input  logic [chm_pkg::LW-1:0]  waddr,
  input  logic                    wtag_en,
  input  logic [31:0]             wtag,
  input  logic                    wage_en,
  input  logic [chm_pkg::LW-1:0]  wage
);
  logic [31:0] tag_mem [chm_pkg::LINES];
  logic [chm_pkg::LW-1:0] age_mem [chm_pkg::LINES];

  always_ff @(posedge clk) begin
    rtag <= tag_mem[raddr];
    rage <= age_mem[raddr];
    if (we && wtag_en) tag_mem[waddr] <= wtag;
    if (we && wage_en) age_mem[waddr] <= wage;
  end
endmodule

// ===== rtl/chm_ctrl.sv =====
// sequencer: lookup, fill and aging passes over the line memory
`include "cache_hit_miss_model_assert.svh"
module chm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  chm_pkg::cfg_t          cfg,
  input  logic                   start,
  input  logic [31:0]            address,
  output logic                   busy,
  output logic                   done,
  output logic                   hit,
  output logic [5:0]             line_index,
  output logic [31:0]            hit_total,
  output logic [31:0]            miss_total
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_AGE  = 3'd3;
  localparam logic [2:0] S_AGEL = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;
  localparam logic [2:0] S_AGE0 = 3'd6;

  logic [2:0] st_r;
  logic [31:0] blk_r;
  logic [1:0] mode_r;
  logic [chm_pkg::LW-1:0] base_r, cnt_r, last_r, rd_r, line_r, lim_r;
  logic [chm_pkg::LW-1:0] maxl_r, maxa_r, inv_r;
  logic inv_f_r, hit_r, all_r;
  logic [chm_pkg::LINES-1:0] valid_r;
  logic [chm_pkg::LINES/2-1:0] lru_r;
  logic [31:0] hc_r, mc_r;

  logic [chm_pkg::LW-1:0] raddr, waddr, wage;
  logic [31:0] rtag;
  logic [chm_pkg::LW-1:0] rage;
  logic we, wtag_en, wage_en;

  chm_store u_store (
    .clk(clk), .raddr(raddr), .rtag(rtag), .rage(rage), .we(we), .waddr(waddr),
    .wtag_en(wtag_en), .wtag(blk_r), .wage_en(wage_en), .wage(wage)
  );

  logic [31:0] blk_in, setf;
  logic [chm_pkg::LW-1:0] s_in;
  assign blk_in = 32'((64'(address)) >> cfg.offset_bits);
  assign setf = blk_in & ((32'd1 << cfg.set_bits) - 32'd1);
  assign s_in = setf[chm_pkg::LW-1:0];

  // first line read for a new request
  logic [chm_pkg::LW-1:0] first_l;
  always_comb begin
    if (cfg.mode == chm_pkg::MODE_DM) first_l = s_in;
    else if (cfg.mode == chm_pkg::MODE_2W) first_l = {s_in[chm_pkg::SW-1:0], 1'b0};
    else first_l = '0;
  end

  logic match;
  assign match = valid_r[rd_r] && (rtag == blk_r);

  logic fa;
  assign fa = (mode_r != chm_pkg::MODE_DM) && (mode_r != chm_pkg::MODE_2W);

  logic [chm_pkg::LW-1:0] fill_l;
  always_comb begin
    if (fa) fill_l = inv_f_r ? inv_r : maxl_r;
    else if (mode_r == chm_pkg::MODE_DM) fill_l = base_r;
    else if (!valid_r[base_r]) fill_l = base_r;
    else if (!valid_r[base_r | 6'd1]) fill_l = base_r | 6'd1;
    else fill_l = lru_r[base_r[chm_pkg::LW-1:1]] ? base_r : (base_r | 6'd1);
  end

  // the read address leads the compare, as the line memory read is registered
  always_comb begin
    raddr = cnt_r;
    if (st_r == S_IDLE) raddr = first_l;
    else if (st_r == S_DONE) raddr = '0;
    we = 1'b0; waddr = line_r; wtag_en = 1'b0; wage_en = 1'b0; wage = '0;
    if (st_r == S_AGE || st_r == S_AGEL) begin
      waddr = rd_r;
      if (rd_r != line_r && valid_r[rd_r] && rage != chm_pkg::AGE_MAX &&
          (all_r || rage < lim_r)) begin
        we = 1'b1; wage_en = 1'b1; wage = rage + 6'd1;
      end
    end else if (st_r == S_AGE0) begin
      we = 1'b1; wage_en = 1'b1; wage = '0;
      wtag_en = !hit_r;
    end else if (st_r == S_DONE && !hit_r && !fa) begin
      // a line filled for the first time starts at age zero
      we = 1'b1; wtag_en = 1'b1; waddr = fill_l;
      wage_en = !valid_r[fill_l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; valid_r <= '0; lru_r <= '0; hc_r <= '0; mc_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: if (start) begin
          blk_r <= blk_in; mode_r <= cfg.mode;
          inv_f_r <= 1'b0; hit_r <= 1'b0; maxa_r <= '0; maxl_r <= '0;
          if (cfg.mode == chm_pkg::MODE_DM) begin
            base_r <= s_in[chm_pkg::LW-1:0] & 6'h3f; cnt_r <= s_in[chm_pkg::LW-1:0];
            last_r <= s_in[chm_pkg::LW-1:0];
            rd_r <= s_in[chm_pkg::LW-1:0];
            st_r <= S_LAST;
          end else if (cfg.mode == chm_pkg::MODE_2W) begin
            base_r <= {s_in[chm_pkg::SW-1:0], 1'b0};
            cnt_r <= {s_in[chm_pkg::SW-1:0], 1'b1};
            rd_r <= {s_in[chm_pkg::SW-1:0], 1'b0};
            last_r <= {s_in[chm_pkg::SW-1:0], 1'b1};
            st_r <= S_SCAN;
          end else begin
            cnt_r <= 6'd1; rd_r <= '0; last_r <= '1; st_r <= S_SCAN;
          end
        end
        S_SCAN, S_LAST: begin
          if (!hit_r) begin
            if (match) begin
              hit_r <= 1'b1; line_r <= rd_r; lim_r <= rage;
            end else begin
              if (!valid_r[rd_r] && !inv_f_r) begin
                inv_f_r <= 1'b1; inv_r <= rd_r;
              end
              if (rage > maxa_r || rd_r == '0) begin
                maxa_r <= rage; maxl_r <= rd_r;
              end
            end
          end
          rd_r <= cnt_r; cnt_r <= cnt_r + 6'd1;
          if (st_r == S_LAST || rd_r == last_r) st_r <= S_DONE;
          else if (cnt_r == last_r) st_r <= S_LAST;
        end
        S_DONE: begin
          if (!hit_r) line_r <= fill_l;
          if (fa) begin
            all_r <= !hit_r;
            cnt_r <= 6'd1; rd_r <= '0; st_r <= S_AGE;
          end else begin
            if (mode_r == chm_pkg::MODE_2W)
              lru_r[base_r[chm_pkg::LW-1:1]] <= hit_r ? line_r[0] : fill_l[0];
            if (!hit_r) valid_r[fill_l] <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        S_AGE: begin
          rd_r <= cnt_r; cnt_r <= cnt_r + 6'd1;
          if (cnt_r == '1) st_r <= S_AGEL;
        end
        S_AGEL: st_r <= S_AGE0;
        S_AGE0: begin
          if (!hit_r) valid_r[line_r] <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
      if (done) begin
        if (hit_r && hc_r != '1) hc_r <= hc_r + 32'd1;
        if (!hit_r && mc_r != '1) mc_r <= mc_r + 32'd1;
      end
    end
  end

  // result strobe: end of a short access, or the final age write
  assign done = (st_r == S_AGE0) || (st_r == S_DONE && !fa);
  assign busy = (st_r != S_IDLE);
  assign hit = hit_r;
  assign line_index = (st_r == S_AGE0) ? line_r : (hit_r ? line_r : fill_l);
  assign hit_total = (hit_r && hc_r != '1) ? hc_r + 32'd1 : hc_r;
  assign miss_total = (!hit_r && mc_r != '1) ? mc_r + 32'd1 : mc_r;

  `CHM_ASSERT(a_busy_start, clk, rst_n, (start && !busy) |=> busy, "start not taken")
  `CHM_ASSERT(a_done_busy, clk, rst_n, done |-> busy, "done while idle")
  `CHM_ASSERT(a_done_idle, clk, rst_n, done |=> !busy, "busy after done")
  `CHM_ASSERT_NR(a_reset, clk, !rst_n |=> !busy, "busy after reset")
endmodule

// ===== rtl/cache_hit_miss_model.sv =====
// busy stays high from start until the result on out_valid in all modes
// fully associative mode does a tag scan and an aging pass of one line
// memory read per cycle each; a new request can be taken in the cycle
// after out_valid
// synchronous active-low reset clears valid bits, lru bits and counters
// out_valid is a one-cycle strobe and the receiver cannot stall
module cache_hit_miss_model (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_address,
  output logic        out_valid,
  output logic        out_hit,
  output logic [5:0]  out_line_index,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_miss_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  chm_pkg::cfg_t cfg;

  chm_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  chm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .start(start), .address(in_address),
    .busy(busy), .done(out_valid), .hit(out_hit), .line_index(out_line_index),
    .hit_total(out_hit_total), .miss_total(out_miss_total)
  );
endmodule
